/* design/fds_pkg.sv */
// Shared types, constants and command codes for the fall detection sequencer.
`timescale 1ns / 1ps
`default_nettype none

package fds_pkg;

    localparam logic [31:0] CONFIRM_TIMEOUT_MS = 32'd10000;
    localparam logic signed [15:0] REF_Z_RESET = 16'sd2509;

    localparam logic [7:0] CFG_REST_MAG_LO         = 8'd0;
    localparam logic [7:0] CFG_REST_MAG_HI         = 8'd1;
    localparam logic [7:0] CFG_STILL_GYRO_MAX      = 8'd2;
    localparam logic [7:0] CFG_FREE_FALL_LEVEL     = 8'd3;
    localparam logic [7:0] CFG_IMPACT_LEVEL        = 8'd4;
    localparam logic [7:0] CFG_POSTURE_COS_LIMIT   = 8'd5;
    localparam logic [7:0] CFG_FREE_FALL_WINDOW_MS = 8'd6;
    localparam logic [7:0] CFG_INACTIVITY_MS       = 8'd7;

    localparam logic [1:0] PHASE_IDLE      = 2'd0;
    localparam logic [1:0] PHASE_FREE_FALL = 2'd1;
    localparam logic [1:0] PHASE_AWAIT     = 2'd2;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        accel_mag;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [15:0]        gyro_mag;
    } fds_in_t;

    typedef struct packed {
        logic       fall_detected;
        logic [1:0] phase;
    } fds_out_t;

    typedef struct packed {
        logic [15:0]        rest_mag_lo;
        logic [15:0]        rest_mag_hi;
        logic [15:0]        still_gyro_max;
        logic [15:0]        free_fall_level;
        logic [15:0]        impact_level;
        logic signed [15:0] posture_cos_limit;
        logic [15:0]        free_fall_window_ms;
        logic [15:0]        inactivity_ms;
    } fds_cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RXX,
        MUL_RYY,
        MUL_RZZ,
        MUL_RXRX,
        MUL_RYRY,
        MUL_RZRZ,
        MUL_XX,
        MUL_YY,
        MUL_ZZ,
        MUL_LL,
        MUL_ADAD,
        MUL_S1S2,
        MUL_PLO,
        MUL_PHI
    } fds_mul_op_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_DOT_INIT,
        ACC_DOT_ADD,
        ACC_S1_INIT,
        ACC_S1_ADD,
        ACC_S2_INIT,
        ACC_S2_ADD,
        ACC_LL_SET,
        ACC_D2_SET,
        ACC_P_SET,
        ACC_R_INIT,
        ACC_R_ADD_HI
    } fds_acc_op_t;

    typedef struct packed {
        logic        load;
        fds_mul_op_t mul_op;
        fds_acc_op_t acc_op;
        logic        decide;
    } fds_cmd_t;

endpackage

`default_nettype wire

/* design/fds_ctrl.sv */
// Sequencer for the fall detector: handshakes and multiply schedule.
`timescale 1ns / 1ps
`default_nettype none

module fds_ctrl
    import fds_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output fds_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.acc_op = ACC_NONE;
        cmd.load   = (state_reg == S_IDLE) && s_valid;
        cmd.decide = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
        if (state_reg == S_CALC) begin
            case (step_reg)
                4'd0: begin cmd.mul_op = MUL_RXX;  cmd.acc_op = ACC_NONE;     end
                4'd1: begin cmd.mul_op = MUL_RYY;  cmd.acc_op = ACC_DOT_INIT; end
                4'd2: begin cmd.mul_op = MUL_RZZ;  cmd.acc_op = ACC_DOT_ADD;  end
                4'd3: begin cmd.mul_op = MUL_RXRX; cmd.acc_op = ACC_DOT_ADD;  end
                4'd4: begin cmd.mul_op = MUL_RYRY; cmd.acc_op = ACC_S1_INIT;  end
                4'd5: begin cmd.mul_op = MUL_RZRZ; cmd.acc_op = ACC_S1_ADD;   end
                4'd6: begin cmd.mul_op = MUL_XX;   cmd.acc_op = ACC_S1_ADD;   end
                4'd7: begin cmd.mul_op = MUL_YY;   cmd.acc_op = ACC_S2_INIT;  end
                4'd8: begin cmd.mul_op = MUL_ZZ;   cmd.acc_op = ACC_S2_ADD;   end
                4'd9: begin cmd.mul_op = MUL_LL;   cmd.acc_op = ACC_S2_ADD;   end
                4'd10: begin cmd.mul_op = MUL_ADAD; cmd.acc_op = ACC_LL_SET;  end
                4'd11: begin cmd.mul_op = MUL_S1S2; cmd.acc_op = ACC_D2_SET;  end
                4'd12: begin cmd.mul_op = MUL_NONE; cmd.acc_op = ACC_P_SET;   end
                4'd13: begin cmd.mul_op = MUL_PLO;  cmd.acc_op = ACC_NONE;    end
                4'd14: begin cmd.mul_op = MUL_PHI;  cmd.acc_op = ACC_R_INIT;  end
                4'd15: begin cmd.mul_op = MUL_NONE; cmd.acc_op = ACC_R_ADD_HI; end
                default: begin cmd.mul_op = MUL_NONE; cmd.acc_op = ACC_NONE;  end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CALC;
                    step_next  = '0;
                end
            end
            S_CALC: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_decide_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (!m_valid_reg || m_ready))
        else $error("result written over a pending beat");

    a_decide_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |=> m_valid_reg)
        else $error("decided result not presented");

    a_load_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_CALC && step_reg == 4'd0))
        else $error("load did not start the schedule");

    a_calc_length: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> ##17 (state_reg == S_DONE))
        else $error("schedule length mismatch");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd.load)
        else $error("load while busy");
`endif

endmodule

`default_nettype wire

/* design/fds_datapath.sv */
// Datapath: sample capture, shared multiplier, accumulators and fall stage logic.
`timescale 1ns / 1ps
`default_nettype none

module fds_datapath
    import fds_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire fds_cfg_t cfg,
    input  wire fds_in_t  s_data,
    input  wire fds_cmd_t cmd,
    output fds_out_t      m_data
);

    // fall sequence state
    logic        iff_reg, ar_reg, rt_reg;
    logic [31:0] ffs_reg, it_reg, rs_reg;
    logic signed [15:0] ref_x_reg, ref_y_reg, ref_z_reg;

    // captured sample
    logic [31:0] now_reg;
    logic [15:0] mag_reg;
    logic signed [15:0] x_reg, y_reg, z_reg;
    logic        still_reg;

    // arithmetic
    logic signed [65:0] prod_reg;
    logic signed [32:0] dot_reg;
    logic [31:0] s1_reg, s2_reg;
    logic [30:0] ll_reg;
    logic [63:0] d2_reg, p_reg;
    logic [95:0] r_reg;

    logic still_c;
    logic signed [32:0] mul_a, mul_b;
    logic [32:0] ad;
    fds_out_t    out_reg;

    // decide
    logic        pc, fall_c;
    logic        idle0, ff_start, f1, impact, f2, ar2, rt2, iff_n, ar_n, rt_n;
    logic [31:0] start1, it2, rs_n;
    logic [95:0] lhs;

    assign still_c = (s_data.accel_mag >= cfg.rest_mag_lo)
                  && (s_data.accel_mag <= cfg.rest_mag_hi)
                  && (s_data.gyro_mag <= cfg.still_gyro_max);

    assign ad = dot_reg[32] ? 33'(-dot_reg) : dot_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_RXX:  begin mul_a = 33'(ref_x_reg); mul_b = 33'(x_reg); end
            MUL_RYY:  begin mul_a = 33'(ref_y_reg); mul_b = 33'(y_reg); end
            MUL_RZZ:  begin mul_a = 33'(ref_z_reg); mul_b = 33'(z_reg); end
            MUL_RXRX: begin mul_a = 33'(ref_x_reg); mul_b = 33'(ref_x_reg); end
            MUL_RYRY: begin mul_a = 33'(ref_y_reg); mul_b = 33'(ref_y_reg); end
            MUL_RZRZ: begin mul_a = 33'(ref_z_reg); mul_b = 33'(ref_z_reg); end
            MUL_XX:   begin mul_a = 33'(x_reg); mul_b = 33'(x_reg); end
            MUL_YY:   begin mul_a = 33'(y_reg); mul_b = 33'(y_reg); end
            MUL_ZZ:   begin mul_a = 33'(z_reg); mul_b = 33'(z_reg); end
            MUL_LL: begin
                mul_a = 33'(cfg.posture_cos_limit);
                mul_b = 33'(cfg.posture_cos_limit);
            end
            MUL_ADAD: begin mul_a = ad; mul_b = ad; end
            MUL_S1S2: begin mul_a = {1'b0, s1_reg}; mul_b = {1'b0, s2_reg}; end
            MUL_PLO:  begin mul_a = {1'b0, p_reg[31:0]}; mul_b = {2'b00, ll_reg}; end
            MUL_PHI:  begin mul_a = {1'b0, p_reg[63:32]}; mul_b = {2'b00, ll_reg}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.acc_op)
            ACC_DOT_INIT: dot_reg <= prod_reg[32:0];
            ACC_DOT_ADD:  dot_reg <= dot_reg + prod_reg[32:0];
            ACC_S1_INIT:  s1_reg  <= prod_reg[31:0];
            ACC_S1_ADD:   s1_reg  <= s1_reg + prod_reg[31:0];
            ACC_S2_INIT:  s2_reg  <= prod_reg[31:0];
            ACC_S2_ADD:   s2_reg  <= s2_reg + prod_reg[31:0];
            ACC_LL_SET:   ll_reg  <= prod_reg[30:0];
            ACC_D2_SET:   d2_reg  <= prod_reg[63:0];
            ACC_P_SET:    p_reg   <= prod_reg[63:0];
            ACC_R_INIT:   r_reg   <= {32'd0, prod_reg[63:0]};
            ACC_R_ADD_HI: r_reg   <= r_reg + {prod_reg[63:0], 32'd0};
            default: ;
        endcase
        if (cmd.load) begin
            now_reg   <= s_data.time_ms;
            mag_reg   <= s_data.accel_mag;
            x_reg     <= s_data.accel_x;
            y_reg     <= s_data.accel_y;
            z_reg     <= s_data.accel_z;
            still_reg <= still_c;
        end
        if (cmd.decide) begin
            out_reg.fall_detected <= fall_c;
            out_reg.phase <= ar_n ? PHASE_AWAIT : (iff_n ? PHASE_FREE_FALL : PHASE_IDLE);
        end
    end

    // posture change on squared terms
    always_comb begin
        lhs = {2'b00, d2_reg, 30'd0};
        if (s1_reg == 32'd0 || s2_reg == 32'd0) begin
            pc = 1'b0;
        end else if (!cfg.posture_cos_limit[15]) begin
            pc = dot_reg[32] || (dot_reg == 33'sd0) || (lhs <= r_reg);
        end else begin
            pc = dot_reg[32] && (lhs >= r_reg);
        end
    end

    always_comb begin
        idle0    = !iff_reg && !ar_reg;
        ff_start = idle0 && (mag_reg < cfg.free_fall_level);
        f1       = iff_reg || ff_start;
        start1   = ff_start ? now_reg : ffs_reg;
        impact   = f1 && (mag_reg > cfg.impact_level);
        f2       = f1 && !impact;
        ar2      = ar_reg || impact;
        it2      = impact ? now_reg : it_reg;
        rt2      = impact ? 1'b0 : rt_reg;
        iff_n    = f2 && !((now_reg - start1) > {16'd0, cfg.free_fall_window_ms});
        ar_n     = ar2;
        rt_n     = rt2;
        rs_n     = rs_reg;
        fall_c   = 1'b0;
        if (ar2) begin
            if (still_reg && pc) begin
                rt_n = 1'b1;
                if (!rt2) begin
                    rs_n = now_reg;
                end
                if ((now_reg - rs_n) >= {16'd0, cfg.inactivity_ms}) begin
                    ar_n   = 1'b0;
                    rt_n   = 1'b0;
                    fall_c = 1'b1;
                end
            end else begin
                rt_n = 1'b0;
            end
            if (!fall_c && ((now_reg - it2) > CONFIRM_TIMEOUT_MS)) begin
                ar_n = 1'b0;
                rt_n = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iff_reg   <= 1'b0;
            ar_reg    <= 1'b0;
            rt_reg    <= 1'b0;
            ffs_reg   <= '0;
            it_reg    <= '0;
            rs_reg    <= '0;
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= REF_Z_RESET;
        end else begin
            if (cmd.load && !iff_reg && !ar_reg && still_c) begin
                ref_x_reg <= s_data.accel_x;
                ref_y_reg <= s_data.accel_y;
                ref_z_reg <= s_data.accel_z;
            end
            if (cmd.decide) begin
                iff_reg <= iff_n;
                ar_reg  <= ar_n;
                rt_reg  <= rt_n;
                ffs_reg <= start1;
                it_reg  <= it2;
                rs_reg  <= rs_n;
            end
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

/* design/fall_detection_sequencer_core.sv */
// Top level of the fall detection sequencer: config registers, controller, datapath.
//
//   channel  dir  handshake              payload
//   s_       in   s_valid / s_ready      s_data  (fds_in_t)
//   m_       out  m_valid / m_ready      m_data  (fds_out_t)
//   cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each sample beat is accepted, run through 16 steps of the shared 33x33
// multiplier, then given the stage decision; no new beat is taken before that.
// A result waiting on m_ready does not block the next sample beat; only the
// decision step waits for the output register to free up.
// Reset (aresetn low, synchronous) restores config, controller and fall state.
// Config writes are always accepted; unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module fall_detection_sequencer_core
    import fds_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire fds_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output fds_out_t         m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    fds_cfg_t cfg_reg;
    fds_cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_mag_lo         <= 16'd2304;
            cfg_reg.rest_mag_hi         <= 16'd2816;
            cfg_reg.still_gyro_max      <= 16'd480;
            cfg_reg.free_fall_level     <= 16'd768;
            cfg_reg.impact_level        <= 16'd7526;
            cfg_reg.posture_cos_limit   <= 16'sd16384;
            cfg_reg.free_fall_window_ms <= 16'd1000;
            cfg_reg.inactivity_ms       <= 16'd3000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_REST_MAG_LO:         cfg_reg.rest_mag_lo         <= cfg_data;
                CFG_REST_MAG_HI:         cfg_reg.rest_mag_hi         <= cfg_data;
                CFG_STILL_GYRO_MAX:      cfg_reg.still_gyro_max      <= cfg_data;
                CFG_FREE_FALL_LEVEL:     cfg_reg.free_fall_level     <= cfg_data;
                CFG_IMPACT_LEVEL:        cfg_reg.impact_level        <= cfg_data;
                CFG_POSTURE_COS_LIMIT:   cfg_reg.posture_cos_limit   <= cfg_data;
                CFG_FREE_FALL_WINDOW_MS: cfg_reg.free_fall_window_ms <= cfg_data;
                CFG_INACTIVITY_MS:       cfg_reg.inactivity_ms       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    fds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fds_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* bench/fall_detection_sequencer_core_test.sv */
// Self-checking testbench for fall_detection_sequencer_core: directed and random IMU streams.
`timescale 1ns / 1ps

module fall_detection_sequencer_core_test;
    import fds_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [7:0] CFG_UNUSED_LOW = CFG_INACTIVITY_MS + 8'd1;
    localparam logic [7:0] CFG_UNUSED_TOP = 8'hFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    fds_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    fds_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    fall_detection_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fds_in_t  sample_q[$];
    fds_out_t due_results[$];
    int       err_count = 0;
    int       n_in = 0;
    int       n_pushed = 0;
    int       cycles = 0;
    logic     calm = 1'b0;
    int       send_gap = 0;
    int       recv_stall = 0;
    int       hold_cnt = 0;
    logic [1:0] hold_fired = '0;

    // predicted block state
    fds_cfg_t           pred_cfg;
    logic               ff_on, await_on, rest_on;
    logic [31:0]        ff_start_t, hit_t, rest_t;
    logic signed [15:0] base_x, base_y, base_z;

    // stimulus plan
    fds_cfg_t    plan_cfg;
    logic [31:0] t_cur;

    function automatic fds_cfg_t default_cfg();
        fds_cfg_t c;
        c.rest_mag_lo         = 16'd2304;
        c.rest_mag_hi         = 16'd2816;
        c.still_gyro_max      = 16'd480;
        c.free_fall_level     = 16'd768;
        c.impact_level        = 16'd7526;
        c.posture_cos_limit   = 16'sd16384;
        c.free_fall_window_ms = 16'd1000;
        c.inactivity_ms       = 16'd3000;
        return c;
    endfunction

    function automatic logic posture_moved(input logic signed [15:0] x, y, z);
        logic signed [63:0] rx, ry, rz, sx, sy, sz, dot, sq1, sq2;
        logic signed [31:0] lim;
        logic [63:0]        mag_dot, lim_sq;
        logic [127:0]       lhs, rhs, w;
        rx = base_x;
        ry = base_y;
        rz = base_z;
        sx = x;
        sy = y;
        sz = z;
        dot = rx * sx + ry * sy + rz * sz;
        sq1 = rx * rx + ry * ry + rz * rz;
        sq2 = sx * sx + sy * sy + sz * sz;
        if (sq1 == 0 || sq2 == 0) return 1'b0;
        lim = pred_cfg.posture_cos_limit;
        if (lim >= 0 && dot <= 0) return 1'b1;
        if (lim < 0 && dot >= 0) return 1'b0;
        mag_dot = (dot < 0) ? -dot : dot;
        lim_sq = lim * lim;
        w = mag_dot;
        lhs = (w * w) << 30;
        w = sq1;
        rhs = w * sq2;
        rhs = rhs * lim_sq;
        return (lim >= 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    function automatic fds_out_t fall_step(input fds_in_t smp);
        logic        still, fall;
        logic [31:0] span;
        fds_out_t    res;
        still = smp.accel_mag >= pred_cfg.rest_mag_lo &&
                smp.accel_mag <= pred_cfg.rest_mag_hi &&
                smp.gyro_mag <= pred_cfg.still_gyro_max;
        fall = 1'b0;
        if (!ff_on && !await_on && still) begin
            base_x = smp.accel_x;
            base_y = smp.accel_y;
            base_z = smp.accel_z;
        end
        if (!ff_on && !await_on && smp.accel_mag < pred_cfg.free_fall_level) begin
            ff_on = 1'b1;
            ff_start_t = smp.time_ms;
        end
        if (ff_on && smp.accel_mag > pred_cfg.impact_level) begin
            ff_on = 1'b0;
            await_on = 1'b1;
            hit_t = smp.time_ms;
            rest_on = 1'b0;
        end
        span = smp.time_ms - ff_start_t;
        if (ff_on && span > {16'd0, pred_cfg.free_fall_window_ms}) ff_on = 1'b0;
        if (await_on) begin
            if (still && posture_moved(smp.accel_x, smp.accel_y, smp.accel_z)) begin
                if (!rest_on) begin
                    rest_on = 1'b1;
                    rest_t = smp.time_ms;
                end
                span = smp.time_ms - rest_t;
                if (span >= {16'd0, pred_cfg.inactivity_ms}) begin
                    await_on = 1'b0;
                    rest_on = 1'b0;
                    fall = 1'b1;
                end
            end else begin
                rest_on = 1'b0;
            end
            span = smp.time_ms - hit_t;
            if (!fall && span > CONFIRM_TIMEOUT_MS) begin
                await_on = 1'b0;
                rest_on = 1'b0;
            end
        end
        res.fall_detected = fall;
        res.phase = await_on ? PHASE_AWAIT : (ff_on ? PHASE_FREE_FALL : PHASE_IDLE);
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // predictor: config beats and sample beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            pred_cfg = default_cfg();
            ff_on = 1'b0;
            await_on = 1'b0;
            rest_on = 1'b0;
            ff_start_t = '0;
            hit_t = '0;
            rest_t = '0;
            base_x = '0;
            base_y = '0;
            base_z = REF_Z_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REST_MAG_LO:         pred_cfg.rest_mag_lo = cfg_data;
                    CFG_REST_MAG_HI:         pred_cfg.rest_mag_hi = cfg_data;
                    CFG_STILL_GYRO_MAX:      pred_cfg.still_gyro_max = cfg_data;
                    CFG_FREE_FALL_LEVEL:     pred_cfg.free_fall_level = cfg_data;
                    CFG_IMPACT_LEVEL:        pred_cfg.impact_level = cfg_data;
                    CFG_POSTURE_COS_LIMIT:   pred_cfg.posture_cos_limit = cfg_data;
                    CFG_FREE_FALL_WINDOW_MS: pred_cfg.free_fall_window_ms = cfg_data;
                    CFG_INACTIVITY_MS:       pred_cfg.inactivity_ms = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                due_results.push_back(fall_step(s_data));
                n_in <= n_in + 1;
            end
        end
    end

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (sample_q.size() != 0) begin
                s_data <= sample_q.pop_front();
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : mon
        fds_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    want = due_results.pop_front();
                    if (m_data.fall_detected !== want.fall_detected)
                        flag_mismatch($sformatf("fall_detected got %b want %b",
                                                m_data.fall_detected, want.fall_detected));
                    if (m_data.phase !== want.phase)
                        flag_mismatch($sformatf("phase got %0d want %0d",
                                                m_data.phase, want.phase));
                end
            end
            if (hold_cnt != 0) begin
                m_ready <= 1'b0;
            end else if (recv_stall != 0) begin
                m_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
            hold_fired <= '0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_fired[0] && n_in >= 70 && sample_q.size() > 20) begin
            hold_cnt <= 600;
            hold_fired[0] <= 1'b1;
        end else if (!hold_fired[1] && n_in >= 470 && sample_q.size() > 20) begin
            hold_cnt <= 600;
            hold_fired[1] <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_cfg(input fds_cfg_t c);
        plan_cfg = c;
        write_reg(CFG_REST_MAG_LO, c.rest_mag_lo);
        write_reg(CFG_REST_MAG_HI, c.rest_mag_hi);
        write_reg(CFG_STILL_GYRO_MAX, c.still_gyro_max);
        write_reg(CFG_FREE_FALL_LEVEL, c.free_fall_level);
        write_reg(CFG_IMPACT_LEVEL, c.impact_level);
        write_reg(CFG_POSTURE_COS_LIMIT, c.posture_cos_limit);
        write_reg(CFG_FREE_FALL_WINDOW_MS, c.free_fall_window_ms);
        write_reg(CFG_INACTIVITY_MS, c.inactivity_ms);
        write_reg(CFG_UNUSED_LOW, 16'($urandom));
        write_reg(CFG_UNUSED_TOP, 16'($urandom));
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (n_in != n_pushed || due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic add_sample(input logic [31:0] dt, input logic [15:0] mag,
                              input logic signed [15:0] x, y, z, input logic [15:0] gyro);
        fds_in_t smp;
        t_cur = t_cur + dt;
        smp.time_ms = t_cur;
        smp.accel_mag = mag;
        smp.accel_x = x;
        smp.accel_y = y;
        smp.accel_z = z;
        smp.gyro_mag = gyro;
        sample_q.push_back(smp);
        n_pushed++;
    endtask

    function automatic logic [15:0] pick_still_mag();
        if (plan_cfg.rest_mag_lo <= plan_cfg.rest_mag_hi)
            return 16'($urandom_range(plan_cfg.rest_mag_hi, plan_cfg.rest_mag_lo));
        return 16'($urandom_range(65535, 0));
    endfunction

    function automatic logic [15:0] pick_still_gyro();
        return 16'($urandom_range(plan_cfg.still_gyro_max, 0));
    endfunction

    function automatic logic [15:0] pick_fall_mag();
        if (plan_cfg.free_fall_level == 0) return 16'd0;
        return 16'($urandom_range(plan_cfg.free_fall_level - 1, 0));
    endfunction

    function automatic logic [15:0] pick_hit_mag();
        if (plan_cfg.impact_level == 16'hFFFF) return 16'hFFFF;
        return 16'($urandom_range(65535, plan_cfg.impact_level + 1));
    endfunction

    function automatic logic signed [15:0] pick_axis();
        int r, v;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            v = $urandom_range(0, 2000) - 1000;
            return v[15:0];
        end
        if (r < 8) return 16'($urandom);
        if (r == 8) return 16'sh8000;
        return 16'sh7FFF;
    endfunction

    task automatic add_fall_sequence();
        logic signed [15:0] px, py, pz, qx, qy, qz;
        logic [31:0]        step;
        int                 n, k, r;
        px = pick_axis();
        py = pick_axis();
        pz = pick_axis();
        if ($urandom_range(0, 9) == 0) begin
            px = '0;
            py = '0;
            pz = '0;
        end
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
            add_sample($urandom_range(10, 100), pick_still_mag(), px, py, pz, pick_still_gyro());
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
            add_sample($urandom_range(1, 40), pick_fall_mag(), pick_axis(), pick_axis(),
                       pick_axis(), 16'($urandom));
        if ($urandom_range(0, 9) < 8) step = $urandom_range(plan_cfg.free_fall_window_ms, 0);
        else step = plan_cfg.free_fall_window_ms + $urandom_range(1, 50);
        add_sample(step, pick_hit_mag(), pick_axis(), pick_axis(), pick_axis(), 16'($urandom));
        case ($urandom_range(0, 3))
            0: begin
                qx = -px;
                qy = -py;
                qz = -pz;
            end
            1: begin
                qx = -py;
                qy = px;
                qz = '0;
            end
            2: begin
                qx = pick_axis();
                qy = pick_axis();
                qz = pick_axis();
            end
            default: begin
                qx = px;
                qy = py;
                qz = pz;
            end
        endcase
        n = $urandom_range(2, 6);
        step = plan_cfg.inactivity_ms / (n - 1) + $urandom_range(0, 20);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                add_sample(step, pick_still_mag(), qx, qy, qz, 16'hFFFF);
            else if (r == 1)
                add_sample(CONFIRM_TIMEOUT_MS + $urandom_range(0, 5), pick_still_mag(),
                           qx, qy, qz, pick_still_gyro());
            else
                add_sample((k == 0) ? $urandom_range(1, 50) : step, pick_still_mag(),
                           qx, qy, qz, pick_still_gyro());
        end
        add_sample($urandom_range(10, 100), pick_still_mag(), pick_axis(), pick_axis(),
                   pick_axis(), pick_still_gyro());
    endtask

    task automatic add_noise();
        logic [31:0] dt;
        if ($urandom_range(0, 9) == 0) dt = $urandom;
        else dt = $urandom_range(0, 500);
        add_sample(dt, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    endtask

    task automatic run_random(input int count);
        int start;
        start = n_pushed;
        while (n_pushed - start < count) begin
            if ($urandom_range(0, 9) < 7) add_fall_sequence();
            else add_noise();
        end
        wait_idle();
    endtask

    initial begin
        fds_cfg_t c;
        int       k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        plan_cfg = default_cfg();
        t_cur = '0;

        // reset settings: full fall, zero vectors, window and confirm timeouts, wrap
        add_sample(0, 16'd2560, 16'sd0, 16'sd0, 16'sd2509, 16'd0);
        add_sample(10, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF);
        add_sample(10, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd0);
        add_sample(10, 16'd2560, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(10, 16'd2560, 16'sd2509, 16'sd0, 16'sd0, 16'd0);
        add_sample(3000, 16'd2560, 16'sd2509, 16'sd0, 16'sd0, 16'd0);
        add_sample(10, 16'd2304, 16'sh8000, 16'sh8000, 16'sh8000, 16'd480);
        add_sample(10, 16'd767, 16'sd0, 16'sd0, 16'sd0, 16'd481);
        add_sample(1001, 16'd2816, 16'sd5, 16'sd5, 16'sd5, 16'd0);
        add_sample(9, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(1000, 16'd7527, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(10001, 16'd2560, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0);
        t_cur = 32'hFFFFFFF0;
        add_sample(0, 16'd2560, 16'sd100, 16'sd0, 16'sd0, 16'd0);
        add_sample(15, 16'd100, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(6, 16'd8000, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(11, 16'd2560, 16'sd0, 16'sd100, 16'sd0, 16'd0);
        add_sample(16, 16'd2560, 16'sd0, 16'sd100, 16'sd0, 16'd481);
        add_sample(16, 16'd2560, 16'sd0, 16'sd100, 16'sd0, 16'd0);
        add_sample(2999, 16'd2560, 16'sd0, 16'sd100, 16'sd0, 16'd0);
        add_sample(1, 16'd2560, 16'sd0, 16'sd100, 16'sd0, 16'd0);
        add_sample(10, 16'd2817, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        add_sample(10, 16'd2303, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        wait_idle();

        apply_cfg(default_cfg());
        run_random(100);

        apply_cfg('0);
        run_random(60);

        c = '1;
        c.posture_cos_limit = 16'sh8000;
        t_cur = 32'hFFFF0000;
        apply_cfg(c);
        run_random(60);

        c = '1;
        c.rest_mag_lo = '0;
        c.posture_cos_limit = 16'sh7FFF;
        apply_cfg(c);
        @(posedge aclk);
        calm <= 1'b1;
        run_random(80);
        calm <= 1'b0;

        for (k = 0; k < 2; k++) begin
            c.rest_mag_lo = 16'($urandom_range(1500, 2500));
            c.rest_mag_hi = 16'(c.rest_mag_lo + $urandom_range(0, 1200));
            c.still_gyro_max = 16'($urandom_range(0, 2000));
            c.free_fall_level = 16'($urandom_range(200, 1500));
            c.impact_level = 16'($urandom_range(3000, 20000));
            c.posture_cos_limit = 16'($urandom);
            c.free_fall_window_ms = 16'($urandom_range(50, 2000));
            c.inactivity_ms = 16'($urandom_range(0, 5000));
            apply_cfg(c);
            run_random(120);
        end

        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
